// File: design/crc_checked_reply_frame_receiver_top_macros.svh
// Assertion macros for the reply frame receiver (ccrfr_*) RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CRC_CHECKED_REPLY_FRAME_RECEIVER_TOP_MACROS_SVH
`define CRC_CHECKED_REPLY_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// check with reset masked
`define CCRFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs through reset
`define CCRFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCRFR_ASSERT(lbl, clk, rst, prop, msg)
`define CCRFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/ccrfr_pkg.sv
// Shared types, constants and the CRC-16 byte step for the reply frame receiver.
// No dependencies; used by every ccrfr_* file and the top level.
`default_nettype none
package ccrfr_pkg;

  localparam int NUM_SLAVES = 16;
  localparam int SLAVE_W    = $clog2(NUM_SLAVES);

  localparam int POS_W = 8;
  localparam logic [POS_W-1:0] MAX_FRAME = POS_W'(255);
  localparam logic [POS_W-1:0] MIN_FRAME = POS_W'(4);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NET_ADDR    = 3'd0,
    CFG_WC_CODE     = 3'd1,
    CFG_RS_CODE     = 3'd2,
    CFG_TEMP_MASK   = 3'd3,
    CFG_HUM_MASK    = 3'd4,
    CFG_LUX_MASK    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NET_ERR   = 2'd1,
    ST_SLAVE_ERR = 2'd2,
    ST_CRC_ERR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] net_address;
    logic [7:0] write_coils_code;
    logic [7:0] read_sensor_code;
    logic [7:0] temperature_mask;
    logic [7:0] humidity_mask;
    logic [7:0] lux_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         rx_byte;
    logic               last_byte;
    logic [SLAVE_W-1:0] expected_slave;
    logic [7:0]         request_op;
    logic [7:0]         read_select;
  } beat_t;

  // frame verdict handed from the frame tracker to the slave table
  typedef struct packed {
    status_t     status;
    logic [31:0] payload;
  } frame_info_t;

  typedef struct packed {
    logic [7:0]  coil_state;
    logic [7:0]  temperature;
    logic [7:0]  humidity;
    logic [15:0] light_level;
  } rec_t;

  // reflected CRC-16 over one byte, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/ccrfr_if.sv
// Valid/ready channel interfaces for frame beats in and result beats out.
// Depends on ccrfr_pkg for the slave index width.
`default_nettype none
interface ccrfr_in_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   rx_byte;
  logic                         last_byte;
  logic [ccrfr_pkg::SLAVE_W-1:0] expected_slave;
  logic [7:0]                   request_op;
  logic [7:0]                   read_select;

  modport source(output valid, rx_byte, last_byte, expected_slave, request_op, read_select,
                 input ready);
  modport sink(input valid, rx_byte, last_byte, expected_slave, request_op, read_select,
               output ready);
endinterface

interface ccrfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  coil_state;
  logic [7:0]  temperature;
  logic [7:0]  humidity;
  logic [15:0] light_level;

  modport source(output valid, frame_status, coil_state, temperature, humidity, light_level,
                 input ready);
  modport sink(input valid, frame_status, coil_state, temperature, humidity, light_level,
               output ready);
endinterface
`default_nettype wire

// File: design/ccrfr_frame.sv
// Per-frame tracker: byte count, running CRC, held tail, address and payload bytes.
// Depends on ccrfr_pkg and the assertion macro header.
`default_nettype none
`include "crc_checked_reply_frame_receiver_top_macros.svh"
module ccrfr_frame (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire ccrfr_pkg::beat_t     beat,
  input  wire logic [7:0]           net_address,
  output ccrfr_pkg::frame_info_t    info
);

  logic [15:0]                 crc, crc_next;
  logic [ccrfr_pkg::POS_W-1:0] pos, pos_next;
  logic [15:0]                 tail, tail_next;
  logic [15:0]                 first2, first2_next;
  logic [31:0]                 payload, payload_next;

  always_comb begin
    crc_next     = (pos >= ccrfr_pkg::POS_W'(2)) ? ccrfr_pkg::crc_byte(crc, tail[15:8]) : crc;
    tail_next    = {tail[7:0], beat.rx_byte};
    first2_next  = first2;
    payload_next = payload;
    case (pos)
      ccrfr_pkg::POS_W'(0): first2_next[15:8]  = beat.rx_byte;
      ccrfr_pkg::POS_W'(1): first2_next[7:0]   = beat.rx_byte;
      ccrfr_pkg::POS_W'(3): payload_next[31:24] = beat.rx_byte;
      ccrfr_pkg::POS_W'(4): payload_next[23:16] = beat.rx_byte;
      ccrfr_pkg::POS_W'(5): payload_next[15:8]  = beat.rx_byte;
      ccrfr_pkg::POS_W'(6): payload_next[7:0]   = beat.rx_byte;
      default: ;
    endcase
    pos_next = (pos != ccrfr_pkg::MAX_FRAME) ? pos + 1'b1 : pos;

    // first failing check decides
    if (first2_next[15:8] != net_address) begin
      info.status = ccrfr_pkg::ST_NET_ERR;
    end else if (first2_next[7:0] != 8'(beat.expected_slave)) begin
      info.status = ccrfr_pkg::ST_SLAVE_ERR;
    end else if (pos_next < ccrfr_pkg::MIN_FRAME || crc_next != tail_next) begin
      info.status = ccrfr_pkg::ST_CRC_ERR;
    end else begin
      info.status = ccrfr_pkg::ST_OK;
    end
    info.payload = payload_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.last_byte)) begin
      crc     <= ccrfr_pkg::CRC_INIT;
      pos     <= '0;
      tail    <= '0;
      first2  <= '0;
      payload <= '0;
    end else if (step) begin
      crc     <= crc_next;
      pos     <= pos_next;
      tail    <= tail_next;
      first2  <= first2_next;
      payload <= payload_next;
    end
  end

  `CCRFR_ASSERT(a_frame_clear, clk, rst, step && beat.last_byte |=> pos == '0 && tail == '0,
                "frame state not cleared after last beat")
  `CCRFR_ASSERT(a_crc_untouched, clk, rst, pos < ccrfr_pkg::POS_W'(2) |-> crc == ccrfr_pkg::CRC_INIT,
                "CRC advanced before third byte")

endmodule
`default_nettype wire

// File: design/ccrfr_table.sv
// Per-slave record table: update on a good reply, read back the record after update.
// Depends on ccrfr_pkg.
`default_nettype none
module ccrfr_table (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire ccrfr_pkg::beat_t      beat,
  input  wire ccrfr_pkg::cfg_t       cfg,
  input  wire ccrfr_pkg::frame_info_t info,
  output ccrfr_pkg::rec_t            rec
);

  logic [7:0]  coil_tab  [ccrfr_pkg::NUM_SLAVES];
  logic [7:0]  temp_tab  [ccrfr_pkg::NUM_SLAVES];
  logic [7:0]  hum_tab   [ccrfr_pkg::NUM_SLAVES];
  logic [15:0] light_tab [ccrfr_pkg::NUM_SLAVES];

  logic good, coil_we, sensor_we;
  logic temp_hit, hum_hit, lux_hit;
  logic temp_we, hum_we, lux_we;

  // each select bit, isolated, is matched against the masks in priority order
  always_comb begin
    logic [7:0] v;
    temp_hit = 1'b0;
    hum_hit  = 1'b0;
    lux_hit  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      v = beat.read_select & (8'd1 << i);
      if (v == cfg.temperature_mask) begin
        temp_hit = 1'b1;
      end else if (v == cfg.humidity_mask) begin
        hum_hit = 1'b1;
      end else if (v == cfg.lux_mask) begin
        lux_hit = 1'b1;
      end
    end
  end

  assign good      = step && beat.last_byte && info.status == ccrfr_pkg::ST_OK;
  assign coil_we   = good && beat.request_op == cfg.write_coils_code;
  assign sensor_we = good && beat.request_op != cfg.write_coils_code
                          && beat.request_op == cfg.read_sensor_code;
  assign temp_we   = sensor_we && temp_hit;
  assign hum_we    = sensor_we && hum_hit;
  assign lux_we    = sensor_we && lux_hit;

  // record as it stands after this beat's update
  assign rec.coil_state  = coil_we ? info.payload[31:24] : coil_tab[beat.expected_slave];
  assign rec.temperature = temp_we ? info.payload[31:24] : temp_tab[beat.expected_slave];
  assign rec.humidity    = hum_we  ? info.payload[23:16] : hum_tab[beat.expected_slave];
  assign rec.light_level = lux_we  ? info.payload[15:0]  : light_tab[beat.expected_slave];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ccrfr_pkg::NUM_SLAVES; s++) begin
        coil_tab[s]  <= '0;
        temp_tab[s]  <= '0;
        hum_tab[s]   <= '0;
        light_tab[s] <= '0;
      end
    end else begin
      if (coil_we) begin
        coil_tab[beat.expected_slave] <= info.payload[31:24];
      end
      if (temp_we) begin
        temp_tab[beat.expected_slave] <= info.payload[31:24];
      end
      if (hum_we) begin
        hum_tab[beat.expected_slave] <= info.payload[23:16];
      end
      if (lux_we) begin
        light_tab[beat.expected_slave] <= info.payload[15:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: design/crc_checked_reply_frame_receiver_top.sv
// Reply frame receiver with CRC-16 (reflected 0xA001, init 0xFFFF) check and slave table.
// An accepted last beat of a frame passes the input register, then the result register, to give its result beat.
// Throughput: one frame beat per cycle; only a stalled result holds up a last beat.
// Reset (synchronous, rst high): config back to defaults, frame state and table cleared.
`default_nettype none
`include "crc_checked_reply_frame_receiver_top_macros.svh"
module crc_checked_reply_frame_receiver_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ccrfr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [7:0]                        cfg_data,
  ccrfr_in_if.sink                               frame,
  ccrfr_out_if.source                            result
);

  // ---------------------------------------------------------------------------
  // Configuration registers; the user must write them only while idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  ccrfr_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.net_address      <= 8'd0;
      cfg.write_coils_code <= 8'd1;
      cfg.read_sensor_code <= 8'd2;
      cfg.temperature_mask <= 8'd1;
      cfg.humidity_mask    <= 8'd2;
      cfg.lux_mask         <= 8'd4;
    end else if (cfg_we) begin
      unique case (ccrfr_pkg::cfg_idx_t'(cfg_idx))
        ccrfr_pkg::CFG_NET_ADDR:  cfg.net_address      <= cfg_data;
        ccrfr_pkg::CFG_WC_CODE:   cfg.write_coils_code <= cfg_data;
        ccrfr_pkg::CFG_RS_CODE:   cfg.read_sensor_code <= cfg_data;
        ccrfr_pkg::CFG_TEMP_MASK: cfg.temperature_mask <= cfg_data;
        ccrfr_pkg::CFG_HUM_MASK:  cfg.humidity_mask    <= cfg_data;
        ccrfr_pkg::CFG_LUX_MASK:  cfg.lux_mask         <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. A held beat moves on (steps the frame logic) unless it is
  // a last beat and the result register is still full and not being taken.
  // ---------------------------------------------------------------------------
  logic             s1_valid;
  ccrfr_pkg::beat_t s1_beat;
  logic             step;
  logic             out_valid;
  logic             in_take;

  assign step        = s1_valid && (!s1_beat.last_byte || !out_valid || result.ready);
  assign frame.ready = !s1_valid || step;
  assign in_take     = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat.rx_byte        <= frame.rx_byte;
      s1_beat.last_byte      <= frame.last_byte;
      s1_beat.expected_slave <= frame.expected_slave;
      s1_beat.request_op     <= frame.request_op;
      s1_beat.read_select    <= frame.read_select;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame tracking (CRC, counts, captured bytes) and the slave record table.
  // ---------------------------------------------------------------------------
  ccrfr_pkg::frame_info_t info;
  ccrfr_pkg::rec_t        rec;

  ccrfr_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .beat        (s1_beat),
    .net_address (cfg.net_address),
    .info        (info)
  );

  ccrfr_table u_table (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .beat (s1_beat),
    .cfg  (cfg),
    .info (info),
    .rec  (rec)
  );

  // ---------------------------------------------------------------------------
  // Result register: one beat per frame, loaded when the last beat steps.
  // ---------------------------------------------------------------------------
  logic             res_load;
  ccrfr_pkg::status_t out_status;
  ccrfr_pkg::rec_t    out_rec;

  assign res_load = step && s1_beat.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= info.status;
      out_rec    <= rec;
    end
  end

  assign result.valid        = out_valid;
  assign result.frame_status = out_status;
  assign result.coil_state   = out_rec.coil_state;
  assign result.temperature  = out_rec.temperature;
  assign result.humidity     = out_rec.humidity;
  assign result.light_level  = out_rec.light_level;

  `CCRFR_ASSERT(a_no_overwrite, clk, rst,
                s1_valid && s1_beat.last_byte && out_valid && !result.ready |-> !step,
                "pending result overwritten")
  `CCRFR_ASSERT(a_take_lands, clk, rst, in_take |=> s1_valid,
                "accepted beat lost at input register")
  `CCRFR_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && !s1_valid,
                       "pipeline not empty after reset")

endmodule
`default_nettype wire
